// ===== design/rmq_pkg.sv =====
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ELEM_W    = 16;
   localparam int RAD_W     = 2 * FRAC_BITS + 3;    // clamped radicand times ONE
   localparam int ROOT_W    = 16;
   localparam int RECIP_W   = 2 * FRAC_BITS;        // floor(2^(2F-1) / S), S >= 1
   localparam int DIFF_W    = ELEM_W + 1;
   localparam int PROD_W    = DIFF_W + RECIP_W;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   typedef logic signed [DIFF_W-1:0] diff_type;

   // Branch plus the three off-diagonal terms, in x, y, z, w order with
   // the root component left out.
   typedef struct packed {
      logic [1:0] br;
      diff_type   da;
      diff_type   db;
      diff_type   dc;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [RAD_W-1:0] rad;
   } sq_in_type;

   typedef struct packed {
      side_type          side;
      logic [ROOT_W-1:0] s;
   } dv_in_type;

   typedef struct packed {
      side_type           side;
      logic [ROOT_W-2:0]  root;
      logic [RECIP_W-1:0] recip;
      logic               zero;
   } sc_in_type;

   typedef struct packed {
      logic [1:0]              br;
      logic [ELEM_W-1:0]       qw;
      logic [ELEM_W-1:0]       qz;
      logic [ELEM_W-1:0]       qy;
      logic [ELEM_W-1:0]       qx;
   } quat_type;

endpackage

// ===== design/rmq_front.sv =====
module rmq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [143:0]          in_mat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rmq_pkg::sq_in_type    out_data
);

   localparam int W = 19;

   logic signed [W-1:0] m [9];
   logic signed [W-1:0] t;
   logic signed [W-1:0] r;
   logic signed [W-1:0] one;
   logic [1:0]          br;
   rmq_pkg::diff_type   da, db, dc;
   rmq_pkg::diff_type   d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
   rmq_pkg::sq_in_type  f_in;
   rmq_pkg::sq_in_type  f_ff;
   logic                v_ff;

   // Sign-extend the nine elements
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = {{(W - rmq_pkg::ELEM_W){in_mat[16*i+15]}}, in_mat[16*i +: 16]};
      end
   end

   // Pick the branch and the radicand
   always_comb begin
      one = W'(1) <<< rmq_pkg::FRAC_BITS;
      t   = m[0] + m[4] + m[8];
      if (!t[W-1]) begin
         br = rmq_pkg::BR_TRACE;
         r  = one + t;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         br = rmq_pkg::BR_X;
         r  = one + m[0] - m[4] - m[8];
      end else if (m[4] > m[8]) begin
         br = rmq_pkg::BR_Y;
         r  = one + m[4] - m[0] - m[8];
      end else begin
         br = rmq_pkg::BR_Z;
         r  = one + m[8] - m[0] - m[4];
      end
   end

   // Off-diagonal sums and differences
   always_comb begin
      d21m12 = rmq_pkg::DIFF_W'(m[7] - m[5]);
      d02m20 = rmq_pkg::DIFF_W'(m[2] - m[6]);
      d10m01 = rmq_pkg::DIFF_W'(m[3] - m[1]);
      s10p01 = rmq_pkg::DIFF_W'(m[3] + m[1]);
      s02p20 = rmq_pkg::DIFF_W'(m[2] + m[6]);
      s21p12 = rmq_pkg::DIFF_W'(m[7] + m[5]);
      unique case (br)
         rmq_pkg::BR_TRACE: begin da = d21m12; db = d02m20; dc = d10m01; end
         rmq_pkg::BR_X:     begin da = s10p01; db = s02p20; dc = d21m12; end
         rmq_pkg::BR_Y:     begin da = s10p01; db = s21p12; dc = d02m20; end
         default:           begin da = s02p20; db = s21p12; dc = d10m01; end
      endcase
   end

   // Clamp the radicand and scale it by ONE
   always_comb begin
      f_in.side.br = br;
      f_in.side.da = da;
      f_in.side.db = db;
      f_in.side.dc = dc;
      if (r[W-1]) begin
         f_in.rad = '0;
      end else begin
         f_in.rad = {r[rmq_pkg::RAD_W-rmq_pkg::FRAC_BITS-1:0], {rmq_pkg::FRAC_BITS{1'b0}}};
      end
   end

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         f_ff <= f_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = f_ff;

endmodule

// ===== design/rmq_sqrt.sv =====
module rmq_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rmq_pkg::sq_in_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rmq_pkg::dv_in_type out_data
);

   localparam int STAGES = 4;
   localparam int STEPS  = 4;    // result bits per stage

   typedef struct packed {
      rmq_pkg::side_type side;
      logic [31:0]       n;
      logic [31:0]       res;
   } st_type;

   st_type st_ff [STAGES];
   st_type st_in [STAGES];
   logic   v_ff  [STAGES];
   logic [STAGES:0] rdy;

   // Run a few digits of the bit-by-bit square root
   function automatic st_type sq_steps(st_type a, int stage);
      st_type      b;
      logic [31:0] bitv;
      logic [31:0] trial;
      b = a;
      for (int j = 0; j < STEPS; j++) begin
         bitv  = 32'd1 << (30 - 2 * (stage * STEPS + j));
         trial = b.res + bitv;
         if (b.n >= trial) begin
            b.n   = b.n - trial;
            b.res = (b.res >> 1) + bitv;
         end else begin
            b.res = b.res >> 1;
         end
      end
      return b;
   endfunction

   assign rdy[STAGES] = out_ready;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      st_type src;
      logic   src_v;

      if (k == 0) begin : g_first
         assign src.side = in_data.side;
         assign src.n    = 32'(in_data.rad);
         assign src.res  = '0;
         assign src_v    = in_valid;
      end else begin : g_next
         assign src   = st_ff[k-1];
         assign src_v = v_ff[k-1];
      end

      assign st_in[k] = sq_steps(src, k);
      assign rdy[k]   = !v_ff[k] || rdy[k+1];

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = v_ff[STAGES-1];
   assign out_data.side = st_ff[STAGES-1].side;
   assign out_data.s    = st_ff[STAGES-1].res[rmq_pkg::ROOT_W-1:0];

endmodule

// ===== design/rmq_recip.sv =====
module rmq_recip (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rmq_pkg::dv_in_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rmq_pkg::sc_in_type out_data
);

   localparam int STAGES = 7;
   localparam int STEPS  = 4;    // quotient bits per stage

   typedef struct packed {
      rmq_pkg::side_type          side;
      logic [rmq_pkg::ROOT_W-1:0] s;
      logic [rmq_pkg::ROOT_W-1:0] rem;
      logic [rmq_pkg::RECIP_W-1:0] q;
   } st_type;

   st_type st_ff [STAGES];
   st_type st_in [STAGES];
   logic   v_ff  [STAGES];
   logic [STAGES:0] rdy;

   // Restoring division of 2^(2F-1) by S, a few quotient bits at a time
   function automatic st_type dv_steps(st_type a, int stage);
      st_type                     b;
      logic [rmq_pkg::ROOT_W:0]   rem_sh;
      int                         i;
      b = a;
      for (int j = 0; j < STEPS; j++) begin
         i      = rmq_pkg::RECIP_W - 1 - (stage * STEPS + j);
         rem_sh = {b.rem, (i == rmq_pkg::RECIP_W - 1)};
         if (rem_sh >= {1'b0, b.s}) begin
            rem_sh = rem_sh - {1'b0, b.s};
            b.q[i] = 1'b1;
         end
         b.rem = rem_sh[rmq_pkg::ROOT_W-1:0];
      end
      return b;
   endfunction

   assign rdy[STAGES] = out_ready;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      st_type src;
      logic   src_v;

      if (k == 0) begin : g_first
         assign src.side = in_data.side;
         assign src.s    = in_data.s;
         assign src.rem  = '0;
         assign src.q    = '0;
         assign src_v    = in_valid;
      end else begin : g_next
         assign src   = st_ff[k-1];
         assign src_v = v_ff[k-1];
      end

      assign st_in[k] = dv_steps(src, k);
      assign rdy[k]   = !v_ff[k] || rdy[k+1];

      // Advance the valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready       = rdy[0];
   assign out_valid      = v_ff[STAGES-1];
   assign out_data.side  = st_ff[STAGES-1].side;
   assign out_data.root  = st_ff[STAGES-1].s[rmq_pkg::ROOT_W-1:1];
   assign out_data.recip = st_ff[STAGES-1].q;
   assign out_data.zero  = (st_ff[STAGES-1].s == '0);

endmodule

// ===== design/rmq_scale.sv =====
module rmq_scale (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rmq_pkg::sc_in_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rmq_pkg::quat_type  out_data
);

   typedef struct packed {
      logic [1:0]                           br;
      logic [rmq_pkg::ROOT_W-2:0]           root;
      logic                                 zero;
      logic [2:0]                           neg;
      logic [2:0]                           nz;
      logic [2:0][rmq_pkg::PROD_W-1:0]      prod;
   } mul_type;

   mul_type             mul_in, mul_ff;
   rmq_pkg::quat_type   q_in, q_ff;
   logic                mv_ff, qv_ff;
   logic                m_rdy, q_rdy;
   rmq_pkg::diff_type   d [3];
   logic [15:0]         v [3];
   logic [15:0]         root16;

   // Magnitude times reciprocal for each off-diagonal term
   always_comb begin
      logic [rmq_pkg::DIFF_W-1:0] mag;
      d[0] = in_data.side.da;
      d[1] = in_data.side.db;
      d[2] = in_data.side.dc;
      mul_in.br   = in_data.side.br;
      mul_in.root = in_data.root;
      mul_in.zero = in_data.zero;
      for (int i = 0; i < 3; i++) begin
         mag            = d[i][rmq_pkg::DIFF_W-1] ? rmq_pkg::DIFF_W'(-d[i]) : d[i];
         mul_in.neg[i]  = d[i][rmq_pkg::DIFF_W-1];
         mul_in.nz[i]   = (d[i] != '0);
         mul_in.prod[i] = {{rmq_pkg::RECIP_W{1'b0}}, mag} *
                          {{rmq_pkg::DIFF_W{1'b0}}, in_data.recip};
      end
   end

   // Drop the fraction, restore the sign and saturate, then place the root and the terms by branch
   always_comb begin
      logic [rmq_pkg::PROD_W-rmq_pkg::FRAC_BITS-1:0] qm;
      for (int i = 0; i < 3; i++) begin
         qm = mul_ff.prod[i][rmq_pkg::PROD_W-1:rmq_pkg::FRAC_BITS];
         if (mul_ff.neg[i]) begin
            if (mul_ff.zero || qm > 32768) begin
               v[i] = 16'h8000;
            end else begin
               v[i] = 16'(-qm[15:0]);
            end
         end else if (mul_ff.zero) begin
            v[i] = mul_ff.nz[i] ? 16'h7fff : 16'h0000;
         end else if (qm > 32767) begin
            v[i] = 16'h7fff;
         end else begin
            v[i] = qm[15:0];
         end
      end
      root16  = {1'b0, mul_ff.root};
      q_in.br = mul_ff.br;
      unique case (mul_ff.br)
         rmq_pkg::BR_TRACE: begin
            q_in.qx = v[0]; q_in.qy = v[1]; q_in.qz = v[2]; q_in.qw = root16;
         end
         rmq_pkg::BR_X: begin
            q_in.qx = root16; q_in.qy = v[0]; q_in.qz = v[1]; q_in.qw = v[2];
         end
         rmq_pkg::BR_Y: begin
            q_in.qx = v[0]; q_in.qy = root16; q_in.qz = v[1]; q_in.qw = v[2];
         end
         default: begin
            q_in.qx = v[0]; q_in.qy = v[1]; q_in.qz = root16; q_in.qw = v[2];
         end
      endcase
   end

   assign q_rdy = !qv_ff || out_ready;
   assign m_rdy = !mv_ff || q_rdy;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         qv_ff <= 1'b0;
      end else begin
         if (m_rdy) begin
            mv_ff <= in_valid;
         end
         if (q_rdy) begin
            qv_ff <= mv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (m_rdy) begin
         mul_ff <= mul_in;
      end
      if (q_rdy) begin
         q_ff <= q_in;
      end
   end

   assign in_ready  = m_rdy;
   assign out_valid = qv_ff;
   assign out_data  = q_ff;

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to quaternion by the trace-branch method, all values signed
// Q2.14. One item enters per clock when the output side never stalls. The front
// stage picks the branch and radicand, four stages work the 16-bit square root
// four bits at a time, seven stages form the 28-bit reciprocal four quotient
// bits at a time, then one multiply stage and one saturate stage, whose register
// drives the outputs. Every stage holds its item on its own, so a stall at the
// output fills bubbles before it backs up to req_tready. A negative radicand
// reads as zero, a zero root saturates every nonzero scaled component, and all
// outputs saturate to 16 bits.
module rotation_matrix_to_quaternion (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, from bit 0)
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // qx, qy, qz, qw (16 bits each, from bit 0)
   output logic [63:0]   rsp_tdata,
   // branch_taken
   output logic [1:0]    rsp_tuser
);

   rmq_pkg::sq_in_type f_data;
   rmq_pkg::dv_in_type s_data;
   rmq_pkg::sc_in_type r_data;
   rmq_pkg::quat_type  q_data;
   logic               f_valid, f_ready;
   logic               s_valid, s_ready;
   logic               r_valid, r_ready;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mat    (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   rmq_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_data  (r_data)
   );

   rmq_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .in_data   (r_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = {q_data.qw, q_data.qz, q_data.qy, q_data.qx};
   assign rsp_tuser = q_data.br;

endmodule
